// File: rtl/core/lbpf_pkg.sv
// lbpf_pkg: shared types, register codes and constants for the light bar pair filter
// no dependencies; imported by every file under rtl/core

package lbpf_pkg;

  // image geometry, centre in Q12.4
  localparam int unsigned IMAGE_WIDTH  = 1280;
  localparam int unsigned IMAGE_HEIGHT = 1024;
  localparam logic [15:0] IMG_CX = 16'(IMAGE_WIDTH * 8);
  localparam logic [15:0] IMG_CY = 16'(IMAGE_HEIGHT * 8);

  // round(tan(50 deg) * 4096)
  localparam logic [12:0] TAN50_Q12 = 13'd4881;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_DIFF = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN_MISM   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_MIN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN_MAX   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_BIG_RATIO  = 3'd7;

  // payload field types
  typedef logic        [15:0] coord_t;
  typedef logic signed [11:0] tilt_t;
  typedef logic        [13:0] size_t;
  typedef logic        [32:0] dist_t;

  typedef struct packed {
    logic [11:0] angle_diff_limit;
    logic [7:0]  offset_x_limit;
    logic [7:0]  offset_y_limit;
    logic [7:0]  length_mismatch_limit;
    logic [7:0]  slope_limit;
    logic [7:0]  span_min;
    logic [7:0]  span_max;
    logic [7:0]  big_plate_ratio;
  } cfg_t;

  // first stage: differences and sums
  typedef struct packed {
    logic [15:0] adx;
    logic [15:0] ady;
    logic [11:0] atd;
    logic [14:0] len_sum;
    logic [13:0] len_max;
    logic [13:0] len_dif;
    logic [14:0] h_sum;
    coord_t      mid_x;
    coord_t      mid_y;
  } prep_t;

  // second stage: cross products, paired at equal widths
  typedef struct packed {
    logic        atd_over;
    logic [28:0] dev_lhs;
    logic [28:0] dev_rhs;
    logic [22:0] offx_lhs;
    logic [22:0] offx_rhs;
    logic [22:0] offy_lhs;
    logic [22:0] offy_rhs;
    logic [21:0] len_lhs;
    logic [21:0] len_rhs;
    logic [23:0] slope_lhs;
    logic [23:0] slope_rhs;
    logic [22:0] span_num;
    logic [22:0] span_lo;
    logic [22:0] span_hi;
    logic [22:0] span_big;
    coord_t      mid_x;
    coord_t      mid_y;
    logic [15:0] ex;
    logic [15:0] ey;
  } prod_t;

endpackage

// File: rtl/core/lbpf_if.sv
// lbpf_in_if / lbpf_out_if: valid/ready channels carrying one bar pair and one verdict
// depends on lbpf_pkg for the field types

interface lbpf_in_if;
  import lbpf_pkg::*;

  logic   valid;
  logic   ready;
  coord_t left_x;
  coord_t left_y;
  tilt_t  left_tilt;
  size_t  left_height;
  size_t  left_len;
  coord_t right_x;
  coord_t right_y;
  tilt_t  right_tilt;
  size_t  right_height;
  size_t  right_len;

  modport source (output valid, left_x, left_y, left_tilt, left_height, left_len,
                  right_x, right_y, right_tilt, right_height, right_len,
                  input ready);
  modport sink   (input valid, left_x, left_y, left_tilt, left_height, left_len,
                  right_x, right_y, right_tilt, right_height, right_len,
                  output ready);
endinterface

interface lbpf_out_if;
  import lbpf_pkg::*;

  logic   valid;
  logic   ready;
  logic   suitable;
  logic   big_plate;
  coord_t mid_x;
  coord_t mid_y;
  dist_t  dist_sq;

  modport source (output valid, suitable, big_plate, mid_x, mid_y, dist_sq, input ready);
  modport sink   (input valid, suitable, big_plate, mid_x, mid_y, dist_sq, output ready);
endinterface

// File: rtl/core/light_bar_pair_filter.sv
// light_bar_pair_filter: top level, geometric check of one candidate light bar pair
// depends on lbpf_pkg, lbpf_if, lbpf_cfg_regs, lbpf_prep, lbpf_mult, lbpf_decide
//
//   channel   direction  handshake          contents
//   in_ch     sink       valid / ready      left and right bar: x, y, tilt, height, len
//   out_ch    source     valid / ready      suitable, big_plate, mid_x, mid_y, dist_sq
//   cfg_*     write      cfg_we             cfg_idx selects a limit, cfg_data its value
//
// four register stages: differences, cross products, compares and squares, output
// one item per cycle unless out_ch.ready stalls; out_ch.valid comes from stage 4
// each stage holds its item until the next stage can take it; empty stages close up
// synchronous active-low reset clears the valid bits and loads the default limits
// limits are read straight from the registers; write them only while idle (unchecked)

module light_bar_pair_filter (
  input  logic                            clk,
  input  logic                            rst_n,
  lbpf_in_if.sink                         in_ch,
  lbpf_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [lbpf_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [lbpf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lbpf_pkg::*;

  cfg_t  cfg;
  logic  prep_v;
  logic  prep_rdy;
  prep_t prep;
  logic  prod_v;
  logic  prod_rdy;
  prod_t prod;

  // limit registers
  lbpf_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .cfg_o    (cfg)
  );

  // stage 1
  lbpf_prep u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .prep_v_o   (prep_v),
    .prep_o     (prep),
    .prep_rdy_i (prep_rdy)
  );

  // stage 2
  lbpf_mult u_mult (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_i      (cfg),
    .prep_v_i   (prep_v),
    .prep_i     (prep),
    .prep_rdy_o (prep_rdy),
    .prod_v_o   (prod_v),
    .prod_o     (prod),
    .prod_rdy_i (prod_rdy)
  );

  // stages 3 and 4
  lbpf_decide u_decide (
    .clk        (clk),
    .rst_n      (rst_n),
    .prod_v_i   (prod_v),
    .prod_i     (prod),
    .prod_rdy_o (prod_rdy),
    .out_ch     (out_ch)
  );

endmodule

// File: rtl/core/lbpf_cfg_regs.sv
// lbpf_cfg_regs: the eight limit registers behind the write-only config port
// depends on lbpf_pkg

module lbpf_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lbpf_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [lbpf_pkg::CFG_DATA_W-1:0]   cfg_data,
  output lbpf_pkg::cfg_t                    cfg_o
);
  import lbpf_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // register decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_ANGLE_DIFF: cfg_nxt.angle_diff_limit      = cfg_data;
        CFG_OFFSET_X:   cfg_nxt.offset_x_limit        = cfg_data[7:0];
        CFG_OFFSET_Y:   cfg_nxt.offset_y_limit        = cfg_data[7:0];
        CFG_LEN_MISM:   cfg_nxt.length_mismatch_limit = cfg_data[7:0];
        CFG_SLOPE:      cfg_nxt.slope_limit           = cfg_data[7:0];
        CFG_SPAN_MIN:   cfg_nxt.span_min              = cfg_data[7:0];
        CFG_SPAN_MAX:   cfg_nxt.span_max              = cfg_data[7:0];
        CFG_BIG_RATIO:  cfg_nxt.big_plate_ratio       = cfg_data[7:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.angle_diff_limit      <= 12'd96;
      cfg_r.offset_x_limit        <= 8'd72;
      cfg_r.offset_y_limit        <= 8'd8;
      cfg_r.length_mismatch_limit <= 8'd8;
      cfg_r.slope_limit           <= 8'd8;
      cfg_r.span_min              <= 8'd17;
      cfg_r.span_max              <= 8'd89;
      cfg_r.big_plate_ratio       <= 8'd50;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

// File: rtl/core/lbpf_prep.sv
// lbpf_prep: stage 1, absolute differences, sums and the pair centre
// depends on lbpf_pkg and lbpf_in_if

module lbpf_prep (
  input  logic            clk,
  input  logic            rst_n,
  lbpf_in_if.sink         in_ch,
  output logic            prep_v_o,
  output lbpf_pkg::prep_t prep_o,
  input  logic            prep_rdy_i
);
  import lbpf_pkg::*;

  logic               v_r;
  prep_t              prep_r;
  prep_t              prep_nxt;
  logic signed [12:0] td;
  logic        [16:0] sum_x;
  logic        [16:0] sum_y;

  assign in_ch.ready = !v_r || prep_rdy_i;

  // differences and sums of the two bars
  always_comb begin
    td    = 13'(in_ch.left_tilt) - 13'(in_ch.right_tilt);
    sum_x = 17'(in_ch.left_x) + 17'(in_ch.right_x);
    sum_y = 17'(in_ch.left_y) + 17'(in_ch.right_y);

    prep_nxt.adx = (in_ch.left_x > in_ch.right_x) ? in_ch.left_x - in_ch.right_x
                                                   : in_ch.right_x - in_ch.left_x;
    prep_nxt.ady = (in_ch.left_y > in_ch.right_y) ? in_ch.left_y - in_ch.right_y
                                                   : in_ch.right_y - in_ch.left_y;
    prep_nxt.atd = td[12] ? 12'(-td) : td[11:0];
    prep_nxt.len_sum = 15'(in_ch.left_len) + 15'(in_ch.right_len);
    prep_nxt.len_max = (in_ch.left_len > in_ch.right_len) ? in_ch.left_len
                                                          : in_ch.right_len;
    prep_nxt.len_dif = (in_ch.left_len > in_ch.right_len) ?
                       in_ch.left_len - in_ch.right_len :
                       in_ch.right_len - in_ch.left_len;
    prep_nxt.h_sum = 15'(in_ch.left_height) + 15'(in_ch.right_height);
    prep_nxt.mid_x = sum_x[16:1];
    prep_nxt.mid_y = sum_y[16:1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ch.ready) begin
      v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      prep_r <= prep_nxt;
    end
  end

  assign prep_v_o = v_r;
  assign prep_o   = prep_r;

endmodule

// File: rtl/core/lbpf_mult.sv
// lbpf_mult: stage 2, cross products against the Q4 and Q5 limits, and centre offsets
// depends on lbpf_pkg

module lbpf_mult (
  input  logic            clk,
  input  logic            rst_n,
  input  lbpf_pkg::cfg_t  cfg_i,
  input  logic            prep_v_i,
  input  lbpf_pkg::prep_t prep_i,
  output logic            prep_rdy_o,
  output logic            prod_v_o,
  output lbpf_pkg::prod_t prod_o,
  input  logic            prod_rdy_i
);
  import lbpf_pkg::*;

  logic  v_r;
  prod_t prod_r;
  prod_t prod_nxt;

  assign prep_rdy_o = !v_r || prod_rdy_i;

  // one small multiplier per ratio test
  always_comb begin
    prod_nxt.atd_over  = prep_i.atd > cfg_i.angle_diff_limit;
    prod_nxt.dev_lhs   = 29'({prep_i.ady, 12'd0});
    prod_nxt.dev_rhs   = 29'(prep_i.adx) * 29'(TAN50_Q12);
    prod_nxt.offx_lhs  = 23'({prep_i.adx, 5'd0});
    prod_nxt.offx_rhs  = 23'(cfg_i.offset_x_limit) * 23'(prep_i.len_sum);
    prod_nxt.offy_lhs  = 23'({prep_i.ady, 5'd0});
    prod_nxt.offy_rhs  = 23'(cfg_i.offset_y_limit) * 23'(prep_i.len_sum);
    prod_nxt.len_lhs   = 22'({prep_i.len_dif, 4'd0});
    prod_nxt.len_rhs   = 22'(cfg_i.length_mismatch_limit) * 22'(prep_i.len_max);
    prod_nxt.slope_lhs = 24'({prep_i.ady, 4'd0});
    prod_nxt.slope_rhs = 24'(cfg_i.slope_limit) * 24'(prep_i.adx);
    prod_nxt.span_num  = 23'({prep_i.adx, 5'd0});
    prod_nxt.span_lo   = 23'(cfg_i.span_min) * 23'(prep_i.h_sum);
    prod_nxt.span_hi   = 23'(cfg_i.span_max) * 23'(prep_i.h_sum);
    prod_nxt.span_big  = 23'(cfg_i.big_plate_ratio) * 23'(prep_i.h_sum);
    prod_nxt.mid_x     = prep_i.mid_x;
    prod_nxt.mid_y     = prep_i.mid_y;
    prod_nxt.ex = (prep_i.mid_x > IMG_CX) ? prep_i.mid_x - IMG_CX : IMG_CX - prep_i.mid_x;
    prod_nxt.ey = (prep_i.mid_y > IMG_CY) ? prep_i.mid_y - IMG_CY : IMG_CY - prep_i.mid_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (prep_rdy_o) begin
      v_r <= prep_v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (prep_rdy_o && prep_v_i) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod_v_o = v_r;
  assign prod_o   = prod_r;

endmodule

// File: rtl/core/lbpf_decide.sv
// lbpf_decide: stage 3 compares and squares, stage 4 distance sum and output register
// depends on lbpf_pkg and lbpf_out_if

module lbpf_decide (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            prod_v_i,
  input  lbpf_pkg::prod_t prod_i,
  output logic            prod_rdy_o,
  lbpf_out_if.source      out_ch
);
  import lbpf_pkg::*;

  // stage 3 registers
  logic        v3_r;
  logic        ok_r;
  logic        big_r;
  coord_t      mx_r;
  coord_t      my_r;
  logic [31:0] sqx_r;
  logic [31:0] sqy_r;
  logic        ok_nxt;
  logic        rdy4;

  // stage 4 registers
  logic        v4_r;
  logic        suit4_r;
  logic        big4_r;
  coord_t      mx4_r;
  coord_t      my4_r;
  dist_t       d2_r;

  assign rdy4       = !v4_r || out_ch.ready;
  assign prod_rdy_o = !v3_r || rdy4;

  // all checks pass
  always_comb begin
    ok_nxt = !prod_i.atd_over
          && !(prod_i.dev_lhs   > prod_i.dev_rhs)
          && !(prod_i.offx_lhs  > prod_i.offx_rhs)
          && !(prod_i.offy_lhs  > prod_i.offy_rhs)
          && !(prod_i.len_lhs   > prod_i.len_rhs)
          && !(prod_i.slope_lhs > prod_i.slope_rhs)
          && !(prod_i.span_num  < prod_i.span_lo)
          && !(prod_i.span_num  > prod_i.span_hi);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (prod_rdy_o) begin
      v3_r <= prod_v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_rdy_o && prod_v_i) begin
      ok_r  <= ok_nxt;
      big_r <= prod_i.span_num > prod_i.span_big;
      mx_r  <= prod_i.mid_x;
      my_r  <= prod_i.mid_y;
      sqx_r <= 32'(prod_i.ex) * 32'(prod_i.ex);
      sqy_r <= 32'(prod_i.ey) * 32'(prod_i.ey);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (rdy4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      suit4_r <= ok_r;
      big4_r  <= big_r;
      mx4_r   <= mx_r;
      my4_r   <= my_r;
      d2_r    <= 33'(sqx_r) + 33'(sqy_r);
    end
  end

  assign out_ch.valid     = v4_r;
  assign out_ch.suitable  = suit4_r;
  assign out_ch.big_plate = big4_r;
  assign out_ch.mid_x     = mx4_r;
  assign out_ch.mid_y     = my4_r;
  assign out_ch.dist_sq   = d2_r;

endmodule
